// ----- rtl/rth_pkg.sv -----
// Shared types and constants for the RGB-to-HSV converter.
// Used by rth_prep, rth_div_cell and the top level rgb_to_hsv.
package rth_pkg;

  // Channel width of one color component.
  localparam int unsigned ChanW    = 8;
  // Hue is a fraction of a full turn with this many bits.
  localparam int unsigned HueW     = 16;
  // Hue divisor is six times delta, at most 1530.
  localparam int unsigned HueDivW  = 11;
  // Saturation dividend is delta times 255.
  localparam int unsigned SatNumW  = 16;
  // One quotient bit of each divider per cell.
  localparam int unsigned NumCells = 16;

  // Data carried from cell to cell along the divider chain.
  typedef struct packed {
    logic               gray;   // delta is zero: hue and saturation are 0
    logic [ChanW-1:0]   value;  // largest channel
    logic [HueDivW-1:0] hrem;   // hue partial remainder
    logic [HueDivW-1:0] hdiv;   // hue divisor, 6*delta
    logic [HueW-1:0]    hquo;   // hue quotient bits so far
    logic [ChanW-1:0]   srem;   // saturation partial remainder
    logic [SatNumW-1:0] snum;   // saturation dividend bits not yet used
    logic [ChanW-1:0]   sdiv;   // saturation divisor, max
    logic [ChanW-1:0]   squo;   // saturation quotient bits so far
  } rth_cell_t;

endpackage

// ----- rtl/rth_prep.sv -----
// Front stage of the RGB-to-HSV converter: max, min, delta and divider operands.
// Depends on rth_pkg for the cell data type and widths.
module rth_prep import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  output rth_cell_t        out_o
);

  logic              red_max, green_max;
  logic [ChanW-1:0]  mx, mn, delta;
  logic signed [11:0] diff_s, off_s, num_s, delta_s;
  logic              valid_q;
  rth_cell_t         data_d, data_q;

  // Pick the largest channel, red before green before blue on ties.
  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      mx = red_i;
    end else if (green_max) begin
      mx = green_i;
    end else begin
      mx = blue_i;
    end
    if ((red_i <= green_i) && (red_i <= blue_i)) begin
      mn = red_i;
    end else if (green_i <= blue_i) begin
      mn = green_i;
    end else begin
      mn = blue_i;
    end
    delta = mx - mn;
  end

  // Hue numerator: sector offset times delta plus the channel difference.
  always_comb begin
    delta_s = $signed({4'b0, delta});
    if (red_max) begin
      diff_s = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
      off_s  = diff_s[11] ? ((delta_s <<< 2) + (delta_s <<< 1)) : 12'sd0;
    end else if (green_max) begin
      diff_s = $signed({4'b0, blue_i}) - $signed({4'b0, red_i});
      off_s  = delta_s <<< 1;
    end else begin
      diff_s = $signed({4'b0, red_i}) - $signed({4'b0, green_i});
      off_s  = delta_s <<< 2;
    end
    num_s = off_s + diff_s;
  end

  // Operands for both dividers.
  always_comb begin
    data_d       = '0;
    data_d.gray  = (delta == '0);
    data_d.value = mx;
    data_d.hrem  = num_s[HueDivW-1:0];
    data_d.hdiv  = HueDivW'({delta, 2'b0}) + HueDivW'({delta, 1'b0});
    data_d.hquo  = '0;
    data_d.srem  = '0;
    data_d.snum  = {delta, {ChanW{1'b0}}} - SatNumW'(delta);
    data_d.sdiv  = mx;
    data_d.squo  = '0;
  end

  // The valid flag is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ----- rtl/rth_div_cell.sv -----
// One cell of the divider chain: a restoring step for hue and one for saturation.
// Depends on rth_pkg for the cell data type and widths.
module rth_div_cell import rth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  rth_cell_t in_i,
  output logic      out_valid_o,
  output rth_cell_t out_o
);

  logic [HueDivW:0] htrial, hsub;
  logic             hge;
  logic [ChanW:0]   strial, ssub;
  logic             sge;
  logic             valid_q;
  rth_cell_t        data_d, data_q;

  // Hue step: double the remainder, subtract the divisor where it fits.
  always_comb begin
    htrial = {in_i.hrem, 1'b0};
    hge    = (htrial >= {1'b0, in_i.hdiv});
    hsub   = htrial - {1'b0, in_i.hdiv};
  end

  // Saturation step: bring down the next dividend bit, subtract where it fits.
  always_comb begin
    strial = {in_i.srem, in_i.snum[SatNumW-1]};
    sge    = (strial >= {1'b0, in_i.sdiv});
    ssub   = strial - {1'b0, in_i.sdiv};
  end

  always_comb begin
    data_d      = in_i;
    data_d.hrem = hge ? hsub[HueDivW-1:0] : htrial[HueDivW-1:0];
    data_d.hquo = {in_i.hquo[HueW-2:0], hge};
    data_d.srem = sge ? ssub[ChanW-1:0] : strial[ChanW-1:0];
    data_d.snum = {in_i.snum[SatNumW-2:0], 1'b0};
    data_d.squo = {in_i.squo[ChanW-2:0], sge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ----- rtl/rgb_to_hsv.sv -----
// Top level of the RGB-to-HSV converter: front stage and a chain of divider cells.
// Depends on rth_pkg, rth_prep and rth_div_cell.
//
// Usage: drive red_i, green_i and blue_i and raise start_i for one cycle per
// item. An item is taken at every rising edge where start_i is high and busy_o
// is low; busy_o is always low, so one pixel can enter every clock cycle.
// Each item gives one result: hue_o (16-bit fraction of a full turn),
// saturation_o and value_o, shown for exactly one cycle with done_o high.
// One front stage computes max, min and the divider operands, then 16 divider
// cells each produce one quotient bit of the hue division and one of the
// saturation division. Throughput is one item per cycle, set by the fully
// pipelined cell chain. Items leave in the order they came in. Reset clears
// all valid flags, so no result is shown until an item has passed the chain.
// The receiver cannot stall: results are not held.
module rgb_to_hsv import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             done_o,
  output logic [HueW-1:0]  hue_o,
  output logic [ChanW-1:0] saturation_o,
  output logic [ChanW-1:0] value_o
);

  logic      chain_valid [0:NumCells];
  rth_cell_t chain_data  [0:NumCells];

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // Front stage.
  rth_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (chain_valid[0]),
    .out_o       (chain_data[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_i        (chain_data[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_o       (chain_data[i+1])
    );
  end

  // Gray pixels give zero hue and saturation.
  assign done_o       = chain_valid[NumCells];
  assign hue_o        = chain_data[NumCells].gray ? '0 : chain_data[NumCells].hquo;
  assign saturation_o = chain_data[NumCells].gray ? '0 : chain_data[NumCells].squo;
  assign value_o      = chain_data[NumCells].value;

endmodule
